// File: sv/bitmask_dict_code_decompressor_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmask dictionary decompressor
// Shared concurrent-assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMASK_DICT_CODE_DECOMPRESSOR_UNIT_DEFINES_SVH
`define BITMASK_DICT_CODE_DECOMPRESSOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Types, constants and token helpers for the bitmask dictionary decompressor.
// ----------------------------------------------------------------------------
package bdc_pkg;

    localparam int DICT_ENTRIES = 16;
    localparam int IDX_W        = 4;
    localparam int WORD_W       = 32;
    localparam int BUF_W        = 42;
    localparam int CNT_W        = 6;
    localparam int REP_W        = 3;
    localparam int LOC_W        = 5;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_FEED = 1'b1
    } act_t;

    typedef enum logic [2:0] {
        TOK_RAW      = 3'd0,
        TOK_RUN      = 3'd1,
        TOK_MASK     = 3'd2,
        TOK_FLIP1    = 3'd3,
        TOK_FLIP2    = 3'd4,
        TOK_FLIP4    = 3'd5,
        TOK_FLIP_TWO = 3'd6,
        TOK_DIRECT   = 3'd7
    } tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PARSE,
        ST_WORD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } dict_req_t;

    // total token length including the 3-bit prefix
    function automatic logic [CNT_W-1:0] tok_len(input tok_t t);
        logic [CNT_W-1:0] len;
        case (t)
            TOK_RAW:      len = CNT_W'(35);
            TOK_RUN:      len = CNT_W'(6);
            TOK_MASK:     len = CNT_W'(16);
            TOK_FLIP1:    len = CNT_W'(12);
            TOK_FLIP2:    len = CNT_W'(12);
            TOK_FLIP4:    len = CNT_W'(12);
            TOK_FLIP_TWO: len = CNT_W'(17);
            TOK_DIRECT:   len = CNT_W'(7);
            default:      len = CNT_W'(35);
        endcase
        return len;
    endfunction

    // pattern given top-aligned; location counts from bit 31, low bits fall off
    function automatic logic [WORD_W-1:0] place(input logic [WORD_W-1:0] top_pat,
                                                input logic [LOC_W-1:0] loc);
        return top_pat >> loc;
    endfunction

endpackage

// File: sv/bitmask_dict_code_decompressor_unit.sv
// ----------------------------------------------------------------------------
// bitmask_dict_code_decompressor_unit
// Bitmask dictionary code decompressor: loads dictionary words and turns a
// compressed byte stream into 32-bit words.
// ----------------------------------------------------------------------------
// A load beat (action 0) writes the dictionary. A feed beat
// (action 1) shifts eight bits into a 42-bit buffer, then the sequencer parses
// complete tokens one at a time: a parse state that issues the dictionary read,
// a word state for the registered read data, then one output beat per word
// (a run token gives 1 to 8 beats from the same register). in_ready comes back
// once the last word of a byte has been accepted and the parse state finds no
// further complete token. run_last marks the final word of a byte.
// ----------------------------------------------------------------------------
`include "bitmask_dict_code_decompressor_unit_defines.svh"

module bitmask_dict_code_decompressor_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic [bdc_pkg::IDX_W-1:0]   dict_index,
    input  logic [bdc_pkg::WORD_W-1:0]  dict_word,
    input  logic [7:0]                  stream_byte,
    input  logic                        end_of_stream,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bdc_pkg::WORD_W-1:0]  out_word,
    output logic                        run_last
);

    bdc_pkg::state_t state_reg, state_next;

    logic [bdc_pkg::BUF_W-1:0]  buf_reg, buf_next;
    logic [bdc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [bdc_pkg::WORD_W-1:0] prev_reg, prev_next;
    logic                       eos_reg, eos_next;
    logic [bdc_pkg::WORD_W-1:0] tok_word_reg, tok_word_next;
    logic [bdc_pkg::WORD_W-1:0] mask_reg, mask_next;
    logic                       use_dict_reg, use_dict_next;
    logic [bdc_pkg::REP_W-1:0]  rem_reg, rem_next;
    logic [bdc_pkg::WORD_W-1:0] word_reg, word_next;
    logic                       last_reg, last_next;

    bdc_pkg::dict_req_t         dreq;
    logic [bdc_pkg::WORD_W-1:0] drdata;

    logic                       in_acc;
    logic                       out_acc;
    logic [bdc_pkg::BUF_W-1:0]  win;
    logic [bdc_pkg::CNT_W-1:0]  sh;
    bdc_pkg::tok_t              pre;
    logic [bdc_pkg::CNT_W-1:0]  len;
    logic                       complete;
    logic [bdc_pkg::CNT_W:0]    cnt_sum;
    logic [bdc_pkg::LOC_W-1:0]  loc_a;
    logic [bdc_pkg::LOC_W-1:0]  loc_b;
    logic [bdc_pkg::WORD_W-1:0] flip_a;
    logic [bdc_pkg::WORD_W-1:0] flip_b;
    logic [bdc_pkg::WORD_W-1:0] cur_word;

    bdc_dict u_dict (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rdata (drdata)
    );

    // token decode at the head of the buffer
    assign sh       = bdc_pkg::CNT_W'(bdc_pkg::BUF_W) - cnt_reg;
    assign win      = buf_reg << sh;
    assign pre      = bdc_pkg::tok_t'(win[41:39]);
    assign len      = bdc_pkg::tok_len(pre);
    assign complete = (cnt_reg >= bdc_pkg::CNT_W'(3)) && (cnt_reg >= len);
    assign loc_a    = win[38:34];
    assign loc_b    = win[33:29];
    assign flip_a   = bdc_pkg::place({1'b1, 31'b0}, loc_a);
    assign flip_b   = bdc_pkg::place({1'b1, 31'b0}, loc_b);
    assign cnt_sum  = {1'b0, cnt_reg} + (bdc_pkg::CNT_W + 1)'(8);
    assign cur_word = use_dict_reg ? (drdata ^ mask_reg) : tok_word_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdc_pkg::ST_IDLE:
            begin
                if (in_valid && (bdc_pkg::act_t'(action) == bdc_pkg::ACT_FEED))
                begin
                    state_next = bdc_pkg::ST_PARSE;
                end
            end
            bdc_pkg::ST_PARSE:
            begin
                state_next = complete ? bdc_pkg::ST_WORD : bdc_pkg::ST_IDLE;
            end
            bdc_pkg::ST_WORD:
            begin
                state_next = bdc_pkg::ST_OUT;
            end
            bdc_pkg::ST_OUT:
            begin
                if (out_ready && (rem_reg == '0))
                begin
                    state_next = bdc_pkg::ST_PARSE;
                end
            end
            default:
            begin
                state_next = bdc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready      = (state_reg == bdc_pkg::ST_IDLE);
        out_valid     = (state_reg == bdc_pkg::ST_OUT);
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        prev_next     = prev_reg;
        eos_next      = eos_reg;
        tok_word_next = tok_word_reg;
        mask_next     = mask_reg;
        use_dict_next = use_dict_reg;
        rem_next      = rem_reg;
        word_next     = word_reg;
        last_next     = last_reg;
        dreq.we       = 1'b0;
        dreq.waddr    = dict_index;
        dreq.wdata    = dict_word;
        dreq.re       = 1'b0;
        dreq.raddr    = win[29:26];
        case (state_reg)
            bdc_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (bdc_pkg::act_t'(action) == bdc_pkg::ACT_LOAD)
                    begin
                        dreq.we = 1'b1;
                    end
                    else
                    begin
                        buf_next = {buf_reg[bdc_pkg::BUF_W-9:0], stream_byte};
                        cnt_next = (cnt_sum > (bdc_pkg::CNT_W + 1)'(bdc_pkg::BUF_W))
                                   ? bdc_pkg::CNT_W'(bdc_pkg::BUF_W)
                                   : cnt_sum[bdc_pkg::CNT_W-1:0];
                        eos_next = end_of_stream;
                    end
                end
            end
            bdc_pkg::ST_PARSE:
            begin
                if (complete)
                begin
                    cnt_next      = cnt_reg - len;
                    use_dict_next = 1'b1;
                    rem_next      = '0;
                    mask_next     = '0;
                    tok_word_next = prev_reg;
                    dreq.re       = 1'b1;
                    case (pre)
                        bdc_pkg::TOK_RAW:
                        begin
                            use_dict_next = 1'b0;
                            tok_word_next = win[38:7];
                        end
                        bdc_pkg::TOK_RUN:
                        begin
                            use_dict_next = 1'b0;
                            rem_next      = win[38:36];
                        end
                        bdc_pkg::TOK_MASK:
                        begin
                            mask_next  = bdc_pkg::place({win[33:30], 28'b0}, loc_a);
                            dreq.raddr = win[29:26];
                        end
                        bdc_pkg::TOK_FLIP1:
                        begin
                            mask_next  = flip_a;
                            dreq.raddr = win[33:30];
                        end
                        bdc_pkg::TOK_FLIP2:
                        begin
                            mask_next  = bdc_pkg::place({2'b11, 30'b0}, loc_a);
                            dreq.raddr = win[33:30];
                        end
                        bdc_pkg::TOK_FLIP4:
                        begin
                            mask_next  = bdc_pkg::place({4'hf, 28'b0}, loc_a);
                            dreq.raddr = win[33:30];
                        end
                        bdc_pkg::TOK_FLIP_TWO:
                        begin
                            // equal locations flip the bit once
                            mask_next  = (loc_a == loc_b) ? flip_a : (flip_a ^ flip_b);
                            dreq.raddr = win[28:25];
                        end
                        bdc_pkg::TOK_DIRECT:
                        begin
                            dreq.raddr = win[38:35];
                        end
                        default:
                        begin
                            use_dict_next = 1'b0;
                        end
                    endcase
                end
                else if (eos_reg)
                begin
                    buf_next = '0;
                    cnt_next = '0;
                end
            end
            bdc_pkg::ST_WORD:
            begin
                prev_next = cur_word;
                word_next = cur_word;
                last_next = (rem_reg == '0) && !complete;
            end
            bdc_pkg::ST_OUT:
            begin
                if (out_acc && (rem_reg != '0))
                begin
                    rem_next  = rem_reg - bdc_pkg::REP_W'(1);
                    last_next = (rem_reg == bdc_pkg::REP_W'(1)) && !complete;
                end
            end
            default:
            begin
                buf_next = buf_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdc_pkg::ST_IDLE;
            buf_reg   <= '0;
            cnt_reg   <= '0;
            prev_reg  <= '0;
            eos_reg   <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
            eos_reg   <= eos_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_word_reg <= tok_word_next;
        mask_reg     <= mask_next;
        use_dict_reg <= use_dict_next;
        word_reg     <= word_next;
        last_reg     <= last_next;
    end

    assign out_word = word_reg;
    assign run_last = last_reg;

    `BDC_ASSERT_NOW(a_idle_cnt, state_reg == bdc_pkg::ST_IDLE, cnt_reg <= bdc_pkg::CNT_W'(34),
        "leftover bits exceed longest partial token")
    `BDC_ASSERT_NEXT(a_feed_parse, in_acc && (bdc_pkg::act_t'(action) == bdc_pkg::ACT_FEED),
        state_reg == bdc_pkg::ST_PARSE, "fed beat did not start parsing")
    `BDC_ASSERT_NOW(a_word_after_parse, state_reg == bdc_pkg::ST_WORD,
        $past(state_reg) == bdc_pkg::ST_PARSE, "word stage without a parsed token")
    `BDC_ASSERT_NOW(a_last_ends_run, out_acc && run_last, rem_reg == '0,
        "run_last while repeats remain")

endmodule

// File: sv/bdc_dict.sv
// ----------------------------------------------------------------------------
// bdc_dict
// Dictionary memory: one write port, one registered read port. Entries never
// written read as zero through per-entry valid bits cleared by reset.
// ----------------------------------------------------------------------------
module bdc_dict (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bdc_pkg::dict_req_t         req,
    output logic [bdc_pkg::WORD_W-1:0] rdata
);

    localparam int DEPTH = 2 ** bdc_pkg::IDX_W;

    logic [bdc_pkg::WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           vld_reg;
    logic [bdc_pkg::WORD_W-1:0] rdata_reg;
    logic                       rvld_reg;
    logic                       w_in_range;
    logic                       r_in_range;

    assign w_in_range = {1'b0, req.waddr} < (bdc_pkg::IDX_W + 1)'(bdc_pkg::DICT_ENTRIES);
    assign r_in_range = {1'b0, req.raddr} < (bdc_pkg::IDX_W + 1)'(bdc_pkg::DICT_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (req.we && w_in_range)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (req.we && w_in_range)
            begin
                vld_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rvld_reg <= r_in_range && vld_reg[req.raddr];
            end
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule
